/* hw/rtl/v2cbp_pkg.sv */
// Shared types, constants and helpers for the voxel backprojection unit.
`default_nettype none
package v2cbp_pkg;

    localparam int COEFS_PER_CAM = 12;
    localparam int MAX_IMAGE     = 4096;
    localparam int Q_BITS        = 13;   // quotient bits kept by the divider
    localparam int REM_W         = 47;   // divider remainder width

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    typedef enum logic [2:0] {
        CFG_VOXEL_SIZE_X  = 3'd0,
        CFG_VOXEL_SIZE_Y  = 3'd1,
        CFG_VOXEL_SIZE_Z  = 3'd2,
        CFG_GRID_CENTER_X = 3'd3,
        CFG_GRID_CENTER_Y = 3'd4,
        CFG_GRID_CENTER_Z = 3'd5,
        CFG_IMAGE_WIDTH   = 3'd6,
        CFG_IMAGE_HEIGHT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] cam;
        logic [7:0] vx;
        logic [7:0] vy;
        logic [2:0] vz;
        logic       ok;      // camera in range
    } t_meta;

    typedef struct packed {
        logic pre;           // camera ok, depth positive, no quotient overflow
        logic negu;
        logic negv;
    } t_dflag;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if (x[49:31] == '0 || x[49:31] == '1) begin
            r = x[31:0];
        end else if (x[49]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/voxel_to_camera_backprojection.sv */
// Path from input accept to result valid: stages A to E, the divider setup and bit slots, then G and H.
// Throughput: one item per cycle while o_stall is low; load items give no result.
// Every stage has its own valid bit, so bubbles are squeezed out under output stall.
// The divider spends one pipeline stage per quotient bit (13 stages).
// Reset (synchronous, active low) empties the pipeline and restores config defaults;
// the coefficient table is not cleared.
`default_nettype none
module voxel_to_camera_backprojection #(
    parameter int GRID_X  = 256,
    parameter int GRID_Y  = 256,
    parameter int GRID_Z  = 8,
    parameter int CAMERAS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [2:0]  i_camera,
    input  wire logic [3:0]  i_coef_index,
    input  wire logic [31:0] i_coef_value,
    input  wire logic [7:0]  i_vox_x,
    input  wire logic [7:0]  i_vox_y,
    input  wire logic [2:0]  i_vox_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [2:0]       o_out_camera,
    output logic [7:0]       o_out_vox_x,
    output logic [7:0]       o_out_vox_y,
    output logic [2:0]       o_out_vox_z,
    output logic [11:0]      o_pixel_col,
    output logic [11:0]      o_pixel_row,
    output logic [23:0]      o_pixel_offset
);
    localparam int AW  = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
    localparam int NC  = v2cbp_pkg::COEFS_PER_CAM;
    localparam int QB  = v2cbp_pkg::Q_BITS;
    localparam int RW  = v2cbp_pkg::REM_W;

    // ---------------- configuration ----------------
    logic [19:0] r_vsize [3];
    logic [31:0] r_org   [3];
    logic [12:0] r_img_w, r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsize[0] <= 20'd32768;
            r_vsize[1] <= 20'd32768;
            r_vsize[2] <= 20'd32768;
            r_org[0]   <= '0;
            r_org[1]   <= '0;
            r_org[2]   <= '0;
            r_img_w    <= 13'd704;
            r_img_h    <= 13'd256;
        end else if (i_cfg_we) begin
            case (v2cbp_pkg::t_cfg_idx'(i_cfg_index))
                v2cbp_pkg::CFG_VOXEL_SIZE_X:  r_vsize[0] <= i_cfg_data[19:0];
                v2cbp_pkg::CFG_VOXEL_SIZE_Y:  r_vsize[1] <= i_cfg_data[19:0];
                v2cbp_pkg::CFG_VOXEL_SIZE_Z:  r_vsize[2] <= i_cfg_data[19:0];
                v2cbp_pkg::CFG_GRID_CENTER_X: r_org[0]   <= i_cfg_data;
                v2cbp_pkg::CFG_GRID_CENTER_Y: r_org[1]   <= i_cfg_data;
                v2cbp_pkg::CFG_GRID_CENTER_Z: r_org[2]   <= i_cfg_data;
                v2cbp_pkg::CFG_IMAGE_WIDTH:   r_img_w    <= i_cfg_data[12:0];
                v2cbp_pkg::CFG_IMAGE_HEIGHT:  r_img_h    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [12:0] img_w_eff, img_h_eff;
    assign img_w_eff = (r_img_w > 13'(v2cbp_pkg::MAX_IMAGE)) ? 13'(v2cbp_pkg::MAX_IMAGE) : r_img_w;
    assign img_h_eff = (r_img_h > 13'(v2cbp_pkg::MAX_IMAGE)) ? 13'(v2cbp_pkg::MAX_IMAGE) : r_img_h;

    // ---------------- stage enables ----------------
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_g_v, r_h_v;
    logic r_dv_v [QB+1];
    logic en_a, en_b, en_c, en_d, en_e, en_g, en_h;
    logic en_dv [QB+1];

    assign en_h = !r_h_v || !i_stall;
    assign en_g = !r_g_v || en_h;
    assign en_dv[QB] = !r_dv_v[QB] || en_g;
    for (genvar k = 0; k < QB; k++) begin : g_en
        assign en_dv[k] = !r_dv_v[k] || en_dv[k+1];
    end
    assign en_e = !r_e_v || en_dv[0];
    assign en_d = !r_d_v || en_e;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;

    assign o_stall = !en_a;

    // ---------------- stage A: accept, coefficient read ----------------
    logic           acc;
    logic           cam_ok;
    logic [4:0]     cam_ext;
    logic [AW-1:0]  cam_addr;
    logic [31:0]    ram_q [NC];
    v2cbp_pkg::t_meta r_a_meta;

    assign acc      = i_valid && en_a;
    assign cam_ext  = {2'b00, i_camera};
    assign cam_ok   = cam_ext < 5'(CAMERAS);
    assign cam_addr = cam_ext[AW-1:0];

    for (genvar k = 0; k < NC; k++) begin : g_coef
        v2cbp_ram #(.WIDTH(32), .DEPTH(CAMERAS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (acc && i_func == v2cbp_pkg::FUNC_LOAD && cam_ok
                      && i_coef_index == 4'(k)),
            .i_waddr (cam_addr),
            .i_wdata (i_coef_value),
            .i_re    (en_a),
            .i_raddr (cam_addr),
            .o_rdata (ram_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= acc && i_func == v2cbp_pkg::FUNC_PROJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_meta <= '{cam: i_camera, vx: i_vox_x, vy: i_vox_y, vz: i_vox_z, ok: cam_ok};
        end
    end

    // ---------------- stage B: centre offset products ----------------
    logic signed [11:0] n_didx [3];
    logic signed [32:0] n_b_off [3];
    logic signed [32:0] r_b_off [3];
    logic [31:0]        r_b_coef [NC];
    v2cbp_pkg::t_meta   r_b_meta;

    assign n_didx[0] = $signed({3'b000, r_a_meta.vx, 1'b0}) - $signed(12'(GRID_X));
    assign n_didx[1] = $signed({3'b000, r_a_meta.vy, 1'b0}) - $signed(12'(GRID_Y));
    assign n_didx[2] = $signed({8'b0, r_a_meta.vz, 1'b0}) - $signed(12'(GRID_Z));
    for (genvar k = 0; k < 3; k++) begin : g_off
        assign n_b_off[k] = $signed({{21{n_didx[k][11]}}, n_didx[k]})
                          * $signed({13'b0, r_vsize[k]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_off  <= n_b_off;
            r_b_coef <= ram_q;
            r_b_meta <= r_a_meta;
        end
    end

    // ---------------- stage C: voxel centre ----------------
    logic signed [31:0] n_c_p [3];
    logic signed [31:0] r_c_p [3];
    logic [31:0]        r_c_coef [NC];
    v2cbp_pkg::t_meta   r_c_meta;

    for (genvar k = 0; k < 3; k++) begin : g_ctr
        logic signed [31:0] half;
        logic signed [32:0] sum;
        assign half = r_b_off[k][32:1];   // arithmetic halve, floor
        assign sum  = $signed({half[31], half}) + $signed({r_org[k][31], r_org[k]});
        assign n_c_p[k] = v2cbp_pkg::sat32(50'(sum));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_p    <= n_c_p;
            r_c_coef <= r_b_coef;
            r_c_meta <= r_b_meta;
        end
    end

    // ---------------- stage D: matrix products ----------------
    logic signed [63:0] r_d_prod [9];
    logic [31:0]        r_d_const [3];
    v2cbp_pkg::t_meta   r_d_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en_d) begin
            r_d_v <= r_c_v;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (en_d) begin
                    r_d_prod[r*3+k] <= $signed(r_c_coef[r*4+k]) * r_c_p[k];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en_d) begin
                r_d_const[r] <= r_c_coef[r*4+3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_meta <= r_c_meta;
        end
    end

    // ---------------- stage E: row sums -> u, v, depth ----------------
    logic signed [31:0] n_e_uvd [3];
    logic signed [31:0] r_e_uvd [3];
    v2cbp_pkg::t_meta   r_e_meta;

    for (genvar r = 0; r < 3; r++) begin : g_sum
        logic signed [49:0] acc50;
        assign acc50 = $signed({{18{r_d_const[r][31]}}, r_d_const[r]})
                     + $signed({{2{r_d_prod[r*3][63]}},   r_d_prod[r*3][63:16]})
                     + $signed({{2{r_d_prod[r*3+1][63]}}, r_d_prod[r*3+1][63:16]})
                     + $signed({{2{r_d_prod[r*3+2][63]}}, r_d_prod[r*3+2][63:16]});
        assign n_e_uvd[r] = v2cbp_pkg::sat32(acc50);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en_e) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_uvd  <= n_e_uvd;
            r_e_meta <= r_d_meta;
        end
    end

    // ---------------- divider: slot 0 is setup, slots 1..QB one bit each ----------------
    // Quotient = (2|x| + d) / (2d), kept to QB bits; larger ones flag overflow (miss).
    logic [RW-1:0]     r_rem_u [QB+1];
    logic [RW-1:0]     r_rem_v [QB+1];
    logic [32:0]       r_den   [QB+1];
    logic [QB-1:0]     r_q_u   [QB+1];
    logic [QB-1:0]     r_q_v   [QB+1];
    v2cbp_pkg::t_dflag r_dfl   [QB+1];
    v2cbp_pkg::t_meta  r_dmeta [QB+1];

    logic signed [31:0] eu, ev, ed;
    logic [32:0]        abs_u, abs_v;
    logic [RW-1:0]      num_u, num_v, den_top;
    logic               d_pos;

    assign eu      = r_e_uvd[0];
    assign ev      = r_e_uvd[1];
    assign ed      = r_e_uvd[2];
    assign d_pos   = !ed[31] && (ed != '0);
    assign abs_u   = eu[31] ? 33'(-$signed({eu[31], eu})) : {1'b0, eu};
    assign abs_v   = ev[31] ? 33'(-$signed({ev[31], ev})) : {1'b0, ev};
    assign num_u   = RW'({abs_u, 1'b0}) + RW'(ed);
    assign num_v   = RW'({abs_v, 1'b0}) + RW'(ed);
    assign den_top = RW'({ed, 1'b0}) << QB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en_dv[0]) begin
            r_dv_v[0] <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_dv[0]) begin
            r_rem_u[0] <= num_u;
            r_rem_v[0] <= num_v;
            r_den[0]   <= {ed, 1'b0};
            r_q_u[0]   <= '0;
            r_q_v[0]   <= '0;
            r_dfl[0]   <= '{pre:  r_e_meta.ok && d_pos
                                  && num_u < den_top && num_v < den_top,
                            negu: eu[31],
                            negv: ev[31]};
            r_dmeta[0] <= r_e_meta;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [RW-1:0] sh;
        logic          ge_u, ge_v;
        assign sh   = RW'(r_den[j]) << (QB - 1 - j);
        assign ge_u = r_rem_u[j] >= sh;
        assign ge_v = r_rem_v[j] >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (en_dv[j+1]) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_dv[j+1]) begin
                r_rem_u[j+1] <= ge_u ? r_rem_u[j] - sh : r_rem_u[j];
                r_rem_v[j+1] <= ge_v ? r_rem_v[j] - sh : r_rem_v[j];
                r_den[j+1]   <= r_den[j];
                r_q_u[j+1]   <= {r_q_u[j][QB-2:0], ge_u};
                r_q_v[j+1]   <= {r_q_v[j][QB-2:0], ge_v};
                r_dfl[j+1]   <= r_dfl[j];
                r_dmeta[j+1] <= r_dmeta[j];
            end
        end
    end

    // ---------------- stage G: hit decision ----------------
    logic [QB-1:0]     qu, qv;
    logic              n_g_hit;
    logic              r_g_hit;
    logic [11:0]       r_g_col, r_g_row;
    v2cbp_pkg::t_meta  r_g_meta;
    v2cbp_pkg::t_dflag fin;

    assign qu  = r_q_u[QB];
    assign qv  = r_q_v[QB];
    assign fin = r_dfl[QB];
    // a negative coordinate only survives when it rounds to zero
    assign n_g_hit = fin.pre
                  && !(fin.negu && qu != '0) && !(fin.negv && qv != '0)
                  && qu < img_w_eff && qv < img_h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en_g) begin
            r_g_v <= r_dv_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            r_g_hit  <= n_g_hit;
            r_g_col  <= n_g_hit ? qu[11:0] : '0;
            r_g_row  <= n_g_hit ? qv[11:0] : '0;
            r_g_meta <= r_dmeta[QB];
        end
    end

    // ---------------- stage H: flat offset, output register ----------------
    logic [24:0] n_h_off;
    logic        r_h_hit;
    logic [11:0] r_h_col, r_h_row;
    logic [23:0] r_h_off;
    v2cbp_pkg::t_meta r_h_meta;

    assign n_h_off = 25'(r_g_row) * 25'(img_w_eff) + 25'(r_g_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (en_h) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_h) begin
            r_h_hit  <= r_g_hit;
            r_h_col  <= r_g_col;
            r_h_row  <= r_g_row;
            r_h_off  <= n_h_off[23:0];
            r_h_meta <= r_g_meta;
        end
    end

    assign o_valid        = r_h_v;
    assign o_hit          = r_h_hit;
    assign o_out_camera   = r_h_meta.cam;
    assign o_out_vox_x    = r_h_meta.vx;
    assign o_out_vox_y    = r_h_meta.vy;
    assign o_out_vox_z    = r_h_meta.vz;
    assign o_pixel_col    = r_h_col;
    assign o_pixel_row    = r_h_row;
    assign o_pixel_offset = r_h_off;
endmodule
`default_nettype wire

/* hw/rtl/v2cbp_ram.sv */
// Generic single write port RAM with registered read.
`default_nettype none
module v2cbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]      i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* hw/rtl/v2cbp_checker.sv */
// Port-level checks for the voxel backprojection unit, bound to the top level.
`default_nettype none
module v2cbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_hit,
    input wire logic [11:0] o_pixel_col,
    input wire logic [11:0] o_pixel_row,
    input wire logic [23:0] o_pixel_offset
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output side free");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_pixel_col == '0 && o_pixel_row == '0
                              && o_pixel_offset == '0)
        else $error("miss carries pixel data");

    a_hit_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_pixel_offset >= 24'(o_pixel_col))
        else $error("flat offset below column");
endmodule

bind voxel_to_camera_backprojection v2cbp_checker u_v2cbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_hit          (o_hit),
    .o_pixel_col    (o_pixel_col),
    .o_pixel_row    (o_pixel_row),
    .o_pixel_offset (o_pixel_offset)
);
`default_nettype wire

/* sim/tb.sv */
// Testbench for the voxel backprojection unit: scoreboard prediction, random idling.
`timescale 1ns / 100ps
`default_nettype none
module tb;

    typedef struct {
        bit        func;
        bit [2:0]  cam;
        bit [3:0]  ci;
        bit [31:0] cv;
        bit [7:0]  vx;
        bit [7:0]  vy;
        bit [2:0]  vz;
    } t_item;

    typedef struct packed {
        bit        hit;
        bit [2:0]  cam;
        bit [7:0]  vx;
        bit [7:0]  vy;
        bit [2:0]  vz;
        bit [11:0] col;
        bit [11:0] row;
        bit [23:0] offs;
    } t_proj;

    class proj_scoreboard;
        bit [31:0] coefs [96];
        bit [19:0] vsize [3];
        bit [31:0] origin [3];
        bit [12:0] img_w, img_h;
        t_proj     pending [$];
        int        mismatches;

        function void reset_state();
            for (int i = 0; i < 3; i++) begin
                vsize[i]  = 20'd32768;
                origin[i] = '0;
            end
            img_w = 13'd704;
            img_h = 13'd256;
        endfunction

        function void write_reg(v2cbp_pkg::t_cfg_idx idx, bit [31:0] data);
            case (idx)
                v2cbp_pkg::CFG_VOXEL_SIZE_X:  vsize[0]  = data[19:0];
                v2cbp_pkg::CFG_VOXEL_SIZE_Y:  vsize[1]  = data[19:0];
                v2cbp_pkg::CFG_VOXEL_SIZE_Z:  vsize[2]  = data[19:0];
                v2cbp_pkg::CFG_GRID_CENTER_X: origin[0] = data;
                v2cbp_pkg::CFG_GRID_CENTER_Y: origin[1] = data;
                v2cbp_pkg::CFG_GRID_CENTER_Z: origin[2] = data;
                v2cbp_pkg::CFG_IMAGE_WIDTH:   img_w     = data[12:0];
                v2cbp_pkg::CFG_IMAGE_HEIGHT:  img_h     = data[12:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint sext(bit [31:0] v);
            return longint'(signed'(v));
        endfunction

        // Rounded quotient half away from zero; 0 when the pixel would be negative.
        function bit pix_div(longint num, longint den, output longint q);
            longint a;
            a = (num < 0) ? -num : num;
            q = (2 * a + den) / (2 * den);
            return !(num < 0 && q != 0);
        endfunction

        function void note_item(t_item it);
            longint p [3];
            longint uvd [3];
            longint gridn [3];
            longint w, h, col, row, acc;
            bit ok;
            t_proj r;
            if (it.func == v2cbp_pkg::FUNC_LOAD) begin
                if (it.ci < v2cbp_pkg::COEFS_PER_CAM)
                    coefs[it.cam * v2cbp_pkg::COEFS_PER_CAM + it.ci] = it.cv;
                return;
            end
            gridn[0] = 256; gridn[1] = 256; gridn[2] = 8;
            p[0] = clip32(((2 * longint'(it.vx) - gridn[0]) * longint'(vsize[0]) >>> 1)
                          + sext(origin[0]));
            p[1] = clip32(((2 * longint'(it.vy) - gridn[1]) * longint'(vsize[1]) >>> 1)
                          + sext(origin[1]));
            p[2] = clip32(((2 * longint'(it.vz) - gridn[2]) * longint'(vsize[2]) >>> 1)
                          + sext(origin[2]));
            for (int rr = 0; rr < 3; rr++) begin
                acc = sext(coefs[it.cam * v2cbp_pkg::COEFS_PER_CAM + rr * 4 + 3]);
                for (int k = 0; k < 3; k++)
                    acc += (sext(coefs[it.cam * v2cbp_pkg::COEFS_PER_CAM + rr * 4 + k])
                            * p[k]) >>> 16;
                uvd[rr] = clip32(acc);
            end
            w = (img_w > v2cbp_pkg::MAX_IMAGE) ? v2cbp_pkg::MAX_IMAGE : img_w;
            h = (img_h > v2cbp_pkg::MAX_IMAGE) ? v2cbp_pkg::MAX_IMAGE : img_h;
            r = '{hit: 0, cam: it.cam, vx: it.vx, vy: it.vy, vz: it.vz,
                  col: 0, row: 0, offs: 0};
            ok = uvd[2] > 0;
            if (ok) ok = pix_div(uvd[0], uvd[2], col);
            if (ok) ok = pix_div(uvd[1], uvd[2], row);
            if (ok && col < w && row < h) begin
                r.hit  = 1;
                r.col  = col[11:0];
                r.row  = row[11:0];
                r.offs = 24'(row * w + col);
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_proj got);
            t_proj e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", got);
                return;
            end
            e = pending.pop_front();
            if (got != e) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid, o_stall;
    logic        i_func;
    logic [2:0]  i_camera;
    logic [3:0]  i_coef_index;
    logic [31:0] i_coef_value;
    logic [7:0]  i_vox_x, i_vox_y;
    logic [2:0]  i_vox_z;
    logic        o_valid, i_stall;
    logic        o_hit;
    logic [2:0]  o_out_camera;
    logic [7:0]  o_out_vox_x, o_out_vox_y;
    logic [2:0]  o_out_vox_z;
    logic [11:0] o_pixel_col, o_pixel_row;
    logic [23:0] o_pixel_offset;

    voxel_to_camera_backprojection dut (.*);

    proj_scoreboard sb;
    int send_idle_pct, recv_stall_pct;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{hit: o_hit, cam: o_out_camera, vx: o_out_vox_x,
                              vy: o_out_vox_y, vz: o_out_vox_z, col: o_pixel_col,
                              row: o_pixel_row, offs: o_pixel_offset});

    // Called at a falling edge; returns at the next falling edge with the item taken.
    // Valid is left high there; the next call, drain or write_reg drives it.
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid      <= 1;
        i_func       <= it.func;
        i_camera     <= it.cam;
        i_coef_index <= it.ci;
        i_coef_value <= it.cv;
        i_vox_x      <= it.vx;
        i_vox_y      <= it.vy;
        i_vox_z      <= it.vz;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(v2cbp_pkg::t_cfg_idx idx, bit [31:0] data);
        i_valid     <= 0;
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 0;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_coef(bit [2:0] cam, bit [3:0] ci, bit [31:0] cv);
        send_item('{func: v2cbp_pkg::FUNC_LOAD, cam: cam, ci: ci, cv: cv,
                    vx: 8'($urandom), vy: 8'($urandom), vz: 3'($urandom)});
    endtask

    // A plausible camera: positive depth near the grid, principal point inside the image.
    task automatic load_camera(bit [2:0] cam, bit plausible);
        int k, cx, cy, wmax, hmax;
        k    = $urandom_range(8, 1);
        wmax = (sb.img_w > v2cbp_pkg::MAX_IMAGE) ? v2cbp_pkg::MAX_IMAGE : sb.img_w;
        hmax = (sb.img_h > v2cbp_pkg::MAX_IMAGE) ? v2cbp_pkg::MAX_IMAGE : sb.img_h;
        cx   = $urandom_range(wmax) / 2;
        cy   = $urandom_range(hmax) / 2;
        for (int i = 0; i < v2cbp_pkg::COEFS_PER_CAM; i++) begin
            if (!plausible) load_coef(cam, 4'(i), $urandom);
            else if (i == 3) load_coef(cam, 4'(i), k * cx * 65536);
            else if (i == 7) load_coef(cam, 4'(i), k * cy * 65536);
            else if (i == 11) load_coef(cam, 4'(i), k * 65536);
            else if (i >= 8) load_coef(cam, 4'(i), $urandom_range(2047) - 1024);
            else load_coef(cam, 4'(i), $urandom_range(32767) - 16384);
        end
    endtask

    task automatic project(bit [2:0] cam, bit [7:0] vx, bit [7:0] vy, bit [2:0] vz);
        send_item('{func: v2cbp_pkg::FUNC_PROJECT, cam: cam, ci: 4'($urandom),
                    cv: $urandom, vx: vx, vy: vy, vz: vz});
    endtask

    task automatic random_config();
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(5))
                0: write_reg(v2cbp_pkg::t_cfg_idx'(i), '0);
                1: write_reg(v2cbp_pkg::t_cfg_idx'(i), 32'hFFFF_FFFF);
                2: write_reg(v2cbp_pkg::t_cfg_idx'(i), $urandom);
                default: write_reg(v2cbp_pkg::t_cfg_idx'(i),
                                   (i < 3) ? $urandom_range(65536) :
                                   (i < 6) ? $urandom_range(131072) - 65536 :
                                             $urandom_range(4096, 1));
            endcase
        end
    endtask

    initial begin
        int r;
        sb = new();
        sb.reset_state();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 0; i_func = 0; i_camera = '0; i_coef_index = '0;
        i_coef_value = '0; i_vox_x = '0; i_vox_y = '0; i_vox_z = '0;
        i_stall = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // every camera gets a full matrix before any projection reads it
        for (int c = 0; c < 8; c++) load_camera(3'(c), c != 7);
        // indices above the matrix are ignored
        for (int ci = 12; ci < 16; ci++) load_coef(3'd0, 4'(ci), $urandom);
        load_coef(3'd6, 4'd11, 32'h8000_0000);    // depth never positive
        project(3'd0, 8'd0, 8'd0, 3'd0);
        project(3'd0, 8'd255, 8'd255, 3'd7);
        project(3'd0, 8'd128, 8'd128, 3'd4);
        project(3'd6, 8'd10, 8'd20, 3'd3);
        project(3'd7, 8'd255, 8'd0, 3'd7);
        project(3'd1, 8'd0, 8'd255, 3'd0);
        drain();
        write_reg(v2cbp_pkg::CFG_VOXEL_SIZE_X, 32'h000F_FFFF);
        write_reg(v2cbp_pkg::CFG_VOXEL_SIZE_Y, '0);
        write_reg(v2cbp_pkg::CFG_VOXEL_SIZE_Z, 32'h000F_FFFF);
        write_reg(v2cbp_pkg::CFG_GRID_CENTER_X, 32'h7FFF_FFFF);
        write_reg(v2cbp_pkg::CFG_GRID_CENTER_Y, 32'h8000_0000);
        write_reg(v2cbp_pkg::CFG_GRID_CENTER_Z, 32'h8000_0000);
        write_reg(v2cbp_pkg::CFG_IMAGE_WIDTH, 32'd0);
        write_reg(v2cbp_pkg::CFG_IMAGE_HEIGHT, 32'h1FFF);
        project(3'd0, 8'd0, 8'd0, 3'd0);
        project(3'd0, 8'd255, 8'd255, 3'd7);
        project(3'd2, 8'd7, 8'd200, 3'd5);
        drain();
        write_reg(v2cbp_pkg::CFG_VOXEL_SIZE_Y, 32'd32768);
        write_reg(v2cbp_pkg::CFG_GRID_CENTER_X, '0);
        write_reg(v2cbp_pkg::CFG_GRID_CENTER_Y, '0);
        write_reg(v2cbp_pkg::CFG_GRID_CENTER_Z, '0);
        write_reg(v2cbp_pkg::CFG_VOXEL_SIZE_X, 32'd32768);
        write_reg(v2cbp_pkg::CFG_VOXEL_SIZE_Z, 32'd32768);
        write_reg(v2cbp_pkg::CFG_IMAGE_WIDTH, 32'd4096);
        write_reg(v2cbp_pkg::CFG_IMAGE_HEIGHT, 32'd1);
        project(3'd3, 8'd128, 8'd128, 3'd4);
        project(3'd4, 8'd130, 8'd126, 3'd3);

        for (int ph = 0; ph < 10; ph++) begin
            drain();    // sender holds off until the pipeline is empty
            send_idle_pct  = (ph < 3) ? 29 : (ph < 6) ? 78 : 0;
            recv_stall_pct = (ph < 3) ? 78 : (ph < 6) ? 29 : 0;
            if (ph != 0) random_config();
            if (ph == 0 || ph == 3 || ph == 6)
                for (int c = 0; c < 8; c++) load_camera(3'(c), $urandom_range(9) != 0);
            for (int n = 0; n < 70; n++) begin
                r = $urandom_range(99);
                if (r < 2) load_camera(3'($urandom), $urandom_range(4) != 0);
                else if (r < 8) load_coef(3'($urandom), 4'($urandom), $urandom);
                else if (r < 20) project(3'($urandom), 8'($urandom), 8'($urandom),
                                         3'($urandom));
                else project(3'($urandom), 8'(128 + $urandom_range(16) - 8),
                             8'(128 + $urandom_range(16) - 8), 3'($urandom));
            end
        end
        drain();
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/v2cbp_pkg.sv
hw/rtl/v2cbp_ram.sv
hw/rtl/voxel_to_camera_backprojection.sv
hw/rtl/v2cbp_checker.sv
sim/tb.sv
